>>> rtl/core/nnps_pkg.sv
package nnps_pkg;

	localparam int COORD_W    = 16;
	localparam int COLOR_W    = 16;
	localparam int TW_W       = 10;
	localparam int TH_W       = 9;
	localparam int LM_W       = 9;
	localparam int TM_W       = 8;
	localparam int ADDR_W     = 21;
	localparam int QUOT_W     = TW_W;
	localparam int PROD_W     = COORD_W + QUOT_W;
	localparam int DIV_STEPS  = QUOT_W;
	localparam int STEP_W     = $clog2(DIV_STEPS + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ADDR_W;
	localparam int LINE_STRIDE = 1024;

	// register reset values
	localparam logic [COORD_W-1:0] SRC_W_RST = COORD_W'(800);
	localparam logic [COORD_W-1:0] SRC_H_RST = COORD_W'(480);
	localparam logic [TW_W-1:0]    TGT_W_RST = TW_W'(800);
	localparam logic [TH_W-1:0]    TGT_H_RST = TH_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_W  = 3'd0,
		CFG_SRC_H  = 3'd1,
		CFG_TGT_W  = 3'd2,
		CFG_TGT_H  = 3'd3,
		CFG_LEFT   = 3'd4,
		CFG_TOP    = 3'd5,
		CFG_BASE   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_use_line;
		logic row_update;
		logic row_base_load;
		logic col_update;
		logic out_load;
	} nnps_cmd_t;

	typedef struct packed {
		logic need_row;
		logic line_dropped;
		logic row_dup;
		logic col_dup;
		logic div_done;
		logic out_free;
	} nnps_stat_t;

endpackage

>>> rtl/core/nnps_div.sv
module nnps_div import nnps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] coord,
	input  logic [COORD_W-1:0] src,
	input  logic [QUOT_W-1:0]  dst,
	output logic               done,
	output logic [QUOT_W-1:0]  quot
);

	logic [QUOT_W-1:0]  dst_eff;
	logic [PROD_W-1:0]  prod;
	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [COORD_W-1:0] rem_q;
	logic [QUOT_W-1:0]  low_q;
	logic [COORD_W-1:0] src_q;
	logic [QUOT_W-1:0]  dmax_q;
	logic               clamp_q;
	logic [COORD_W:0]   trial;
	logic [COORD_W:0]   diff;
	logic               ge;

	// zero target acts as one
	assign dst_eff = (dst == '0) ? QUOT_W'(1) : dst;
	assign prod    = PROD_W'(coord) * PROD_W'(dst_eff);

	// restoring step: next dividend bit comes off the top of low_q
	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, src_q};
	assign ge    = (trial >= {1'b0, src_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= prod[PROD_W-1:QUOT_W];
			low_q   <= prod[QUOT_W-1:0];
			src_q   <= src;
			dmax_q  <= dst_eff - 1'b1;
			// coord >= src means the quotient reaches dst, also covers src of zero
			clamp_q <= (coord >= src);
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			low_q <= {low_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = clamp_q ? dmax_q : low_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy_q) |-> done_q)
		else $error("divider finished without done");

endmodule

>>> rtl/core/nnps_ctrl.sv
module nnps_ctrl import nnps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  nnps_stat_t stat,
	output nnps_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		START,
		ROW_WAIT,
		ROW_DECIDE,
		COL_WAIT,
		COL_DECIDE,
		ADDR
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= START;
				end
				START: begin
					if (stat.need_row) state_q <= ROW_WAIT;
					else if (stat.line_dropped) state_q <= IDLE;
					else state_q <= COL_WAIT;
				end
				ROW_WAIT: begin
					if (stat.div_done) state_q <= ROW_DECIDE;
				end
				ROW_DECIDE: begin
					state_q <= stat.row_dup ? IDLE : COL_WAIT;
				end
				COL_WAIT: begin
					if (stat.div_done) state_q <= COL_DECIDE;
				end
				COL_DECIDE: begin
					state_q <= stat.col_dup ? IDLE : ADDR;
				end
				ADDR: begin
					if (stat.out_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				cmd.capture = in_valid;
			end
			START: begin
				if (stat.need_row) begin
					cmd.div_start    = 1'b1;
					cmd.div_use_line = 1'b1;
				end else if (!stat.line_dropped) begin
					cmd.div_start = 1'b1;
				end
			end
			ROW_WAIT: begin
			end
			ROW_DECIDE: begin
				cmd.row_update = 1'b1;
				cmd.div_start  = !stat.row_dup;
			end
			COL_WAIT: begin
				cmd.row_base_load = 1'b1;
			end
			COL_DECIDE: begin
				cmd.col_update = !stat.col_dup;
			end
			ADDR: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != IDLE);

	assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ROW_WAIT || state_q == COL_WAIT))
		else $error("divider result arrived outside a wait state");

endmodule

>>> rtl/core/nnps_dp.sv
module nnps_dp import nnps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [COORD_W-1:0]    column,
	input  logic [COORD_W-1:0]    line,
	input  logic [COLOR_W-1:0]    color,
	input  logic                  block_start,
	input  logic                  line_start,
	input  nnps_cmd_t             cmd,
	output nnps_stat_t            stat,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [ADDR_W-1:0]     write_address,
	output logic [COLOR_W-1:0]    write_color,
	output logic                  burst
);

	logic [COORD_W-1:0] src_w_q;
	logic [COORD_W-1:0] src_h_q;
	logic [TW_W-1:0]    tgt_w_q;
	logic [TH_W-1:0]    tgt_h_q;
	logic [LM_W-1:0]    left_q;
	logic [TM_W-1:0]    top_q;
	logic [ADDR_W-1:0]  base_q;

	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] line_q;
	logic [COLOR_W-1:0] color_q;
	logic               need_row_q;

	logic [TH_W-1:0]    last_line_q;
	logic               last_line_valid_q;
	logic               line_dropped_q;
	logic [TW_W-1:0]    last_col_q;
	logic               last_col_valid_q;
	logic [ADDR_W-1:0]  last_addr_q;
	logic               last_addr_valid_q;

	logic [ADDR_W-1:0]  row_base_q;
	logic [ADDR_W-1:0]  addr_q;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [COLOR_W-1:0] wr_color_q;
	logic               burst_q;

	logic               div_done;
	logic [QUOT_W-1:0]  quot;
	logic [COORD_W-1:0] div_coord;
	logic [COORD_W-1:0] div_src;
	logic [QUOT_W-1:0]  div_dst;
	logic               row_dup;
	logic               col_dup;
	logic [TH_W:0]      line_sum;
	logic [ADDR_W-1:0]  row_off;
	logic               burst_next;
	logic               out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_W_RST;
			src_h_q <= SRC_H_RST;
			tgt_w_q <= TGT_W_RST;
			tgt_h_q <= TGT_H_RST;
			left_q  <= '0;
			top_q   <= '0;
			base_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_W: src_w_q <= cfg_data[COORD_W-1:0];
				CFG_SRC_H: src_h_q <= cfg_data[COORD_W-1:0];
				CFG_TGT_W: tgt_w_q <= cfg_data[TW_W-1:0];
				CFG_TGT_H: tgt_h_q <= cfg_data[TH_W-1:0];
				CFG_LEFT:  left_q  <= cfg_data[LM_W-1:0];
				CFG_TOP:   top_q   <= cfg_data[TM_W-1:0];
				CFG_BASE:  base_q  <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// shared divider, one coordinate at a time
	assign div_coord = cmd.div_use_line ? line_q : column_q;
	assign div_src   = cmd.div_use_line ? src_h_q : src_w_q;
	assign div_dst   = cmd.div_use_line ? QUOT_W'(tgt_h_q) : tgt_w_q;

	nnps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.coord  (div_coord),
		.src    (div_src),
		.dst    (div_dst),
		.done   (div_done),
		.quot   (quot)
	);

	assign row_dup = last_line_valid_q && (quot[TH_W-1:0] == last_line_q);
	assign col_dup = last_col_valid_q && (quot == last_col_q);

	assign line_sum   = (TH_W+1)'(top_q) + (TH_W+1)'(last_line_q);
	assign row_off    = ADDR_W'(line_sum) * ADDR_W'(LINE_STRIDE);
	assign burst_next = last_addr_valid_q && (addr_q == last_addr_q + 1'b1);
	assign out_free   = !out_valid_q || !out_stall;

	// request capture, row base, column address and output register loads
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			column_q <= column;
			line_q   <= line;
			color_q  <= color;
		end
		if (cmd.row_base_load) row_base_q <= base_q + row_off;
		if (cmd.col_update) addr_q <= row_base_q + ADDR_W'(left_q) + ADDR_W'(quot);
		if (cmd.out_load) begin
			wr_addr_q  <= addr_q;
			wr_color_q <= color_q;
			burst_q    <= burst_next;
		end
	end

	// row, column and address history, row-needed flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_row_q        <= 1'b0;
			last_line_q       <= '0;
			last_line_valid_q <= 1'b0;
			line_dropped_q    <= 1'b0;
			last_col_q        <= '0;
			last_col_valid_q  <= 1'b0;
			last_addr_q       <= '0;
			last_addr_valid_q <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cmd.capture) begin
				need_row_q <= block_start || line_start || !last_line_valid_q;
				if (block_start) begin
					last_line_valid_q <= 1'b0;
					last_col_valid_q  <= 1'b0;
					last_addr_valid_q <= 1'b0;
					line_dropped_q    <= 1'b0;
				end
			end
			if (cmd.row_update) begin
				if (row_dup) begin
					line_dropped_q <= 1'b1;
				end else begin
					line_dropped_q    <= 1'b0;
					last_line_q       <= quot[TH_W-1:0];
					last_line_valid_q <= 1'b1;
					last_col_valid_q  <= 1'b0;
				end
			end
			if (cmd.col_update) begin
				last_col_q       <= quot;
				last_col_valid_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q       <= 1'b1;
				last_addr_q       <= addr_q;
				last_addr_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.need_row     = need_row_q;
		stat.line_dropped = line_dropped_q;
		stat.row_dup      = row_dup;
		stat.col_dup      = col_dup;
		stat.div_done     = div_done;
		stat.out_free     = out_free;
	end

	assign out_valid     = out_valid_q;
	assign write_address = wr_addr_q;
	assign write_color   = wr_color_q;
	assign burst         = burst_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (last_addr_valid_q && last_addr_q == wr_addr_q))
		else $error("address history out of step with output");

endmodule

>>> rtl/core/nearest_neighbor_pixel_scaler.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// in       | in_valid / in_stall  | column, line, color, block_start, line_start
// out      | out_valid / out_stall| write_address, write_color, burst
// cfg      | cfg_write            | cfg_index, cfg_data
//
// one pixel at a time: no request is taken until the last one is done; a pixel that opens a row
// maps its line and then its column, a mid-row pixel maps only its column, and a pixel drops
// out when its line repeats the kept line or its column repeats; a dropped row skips the divider
// each mapping runs on the shared ten-step radix-2 divider, once per coordinate
// arst_n clears history and control, registers take their documented reset values
// a waiting result sits in the output register; the next request waits only at its address step
module nearest_neighbor_pixel_scaler import nnps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_W-1:0]    column,
	input  logic [COORD_W-1:0]    line,
	input  logic [COLOR_W-1:0]    color,
	input  logic                  block_start,
	input  logic                  line_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ADDR_W-1:0]     write_address,
	output logic [COLOR_W-1:0]    write_color,
	output logic                  burst
);

	// commands from the sequencer, status back from the datapath
	nnps_cmd_t  cmd;
	nnps_stat_t stat;

	// sequencer: row mapping, column mapping, address, output hand-off
	nnps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: registers, divider, history and output register
	nnps_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.column        (column),
		.line          (line),
		.color         (color),
		.block_start   (block_start),
		.line_start    (line_start),
		.cmd           (cmd),
		.stat          (stat),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.write_address (write_address),
		.write_color   (write_color),
		.burst         (burst)
	);

endmodule
